/* sv/env_sensor_compensation_assert.svh */
// Assertion macros shared by the compensation RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ENV_SENSOR_COMPENSATION_ASSERT_SVH
`define ENV_SENSOR_COMPENSATION_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define ESC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ESC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/esc_pkg.sv */
// Shared constants and helpers for the environmental sensor compensation block.
// Used by the top level, the divider, the checker and the testbench; no dependencies.
package esc_pkg;

    // Channel disabled codes
    localparam logic [19:0] DIS_TP  = 20'h80000;
    localparam logic [15:0] DIS_HUM = 16'h8000;

    // Fine temperature offsets, humidity limit and other compensation constants
    localparam logic [63:0] TF_PRESS_OFS = 64'd128000;
    localparam logic [31:0] TF_HUM_OFS   = 32'd76800;
    localparam logic [31:0] HUM_MAX      = 32'd419430400;
    localparam logic [63:0] PRESS_BASE   = 64'd1048576;
    localparam logic [63:0] PRESS_SCALE  = 64'd3125;
    localparam logic [63:0] P1_BIAS      = 64'h0000_8000_0000_0000;
    localparam logic [31:0] HUM_RND      = 32'd16384;
    localparam logic [31:0] HUM_W_OFS    = 32'd2097152;
    localparam logic [31:0] HUM_Z_OFS    = 32'd32768;
    localparam logic [31:0] HUM_W_RND    = 32'd8192;
    localparam logic [31:0] TEMP_RND     = 32'd128;

    // Divider: one quotient bit per stage
    localparam int DIV_STAGES = 64;

    // Register indexes (byte address 8*index)
    localparam logic [2:0] REG_CAL_TEMP       = 3'd0;
    localparam logic [2:0] REG_CAL_PRESS_LOW  = 3'd1;
    localparam logic [2:0] REG_CAL_PRESS_HIGH = 3'd2;
    localparam logic [2:0] REG_CAL_PRESS_LAST = 3'd3;
    localparam logic [2:0] REG_CAL_HUM        = 3'd4;

    // Arithmetic right shifts on raw words
    function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
        return 64'($signed(x) >>> n);
    endfunction

    // Sign extensions of calibration fields
    function automatic logic [63:0] sx16_64(input logic [15:0] x);
        return {{48{x[15]}}, x};
    endfunction

    function automatic logic [31:0] sx16_32(input logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

endpackage

/* sv/esc_mul64.sv */
// Two-stage multiplier giving the low 64 bits of a 64 x 64 product.
// Built from 32 x 32 partial products; no package dependencies.
module esc_mul64 (
    input  logic        aclk,
    input  logic        en_a,   // load enable of the partial-product stage
    input  logic        en_b,   // load enable of the sum stage
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p
);

    logic [63:0] pp_lo_reg;
    logic [31:0] pp_mid_reg;
    logic [63:0] p_reg;
    logic [31:0] mid_a;
    logic [31:0] mid_b;

    // Cross terms only matter in their low 32 bits
    assign mid_a = 32'(a[31:0] * b[63:32]);
    assign mid_b = 32'(a[63:32] * b[31:0]);

    // Partial products
    always_ff @(posedge aclk) begin
        if (en_a) begin
            pp_lo_reg  <= 64'(a[31:0]) * 64'(b[31:0]);
            pp_mid_reg <= mid_a + mid_b;
        end
    end

    // Final sum
    always_ff @(posedge aclk) begin
        if (en_b) begin
            p_reg <= pp_lo_reg + {pp_mid_reg, 32'd0};
        end
    end

    assign p = p_reg;

endmodule

/* sv/esc_sdiv.sv */
// Pipelined radix-2 restoring divider on 64-bit magnitudes.
// One quotient bit per stage; depends on esc_pkg for the stage count.
module esc_sdiv (
    input  logic                           aclk,
    input  logic [esc_pkg::DIV_STAGES-1:0] en,   // per-stage load enables
    input  logic [63:0]                    num,
    input  logic [63:0]                    den,
    output logic [63:0]                    quo
);

    logic [63:0] rem_reg [esc_pkg::DIV_STAGES];
    logic [63:0] quo_reg [esc_pkg::DIV_STAGES];
    logic [63:0] den_reg [esc_pkg::DIV_STAGES];

    for (genvar i = 0; i < esc_pkg::DIV_STAGES; i++) begin : g_st
        logic [63:0] prem;
        logic [63:0] pquo;
        logic [63:0] pden;
        logic [64:0] trial;
        logic [64:0] diff;

        // Previous stage, or the operands for the first one
        if (i == 0) begin : g_first
            assign prem = 64'd0;
            assign pquo = num;
            assign pden = den;
        end else begin : g_next
            assign prem = rem_reg[i-1];
            assign pquo = quo_reg[i-1];
            assign pden = den_reg[i-1];
        end

        // Shift in the next dividend bit and try the subtract
        assign trial = {prem, pquo[63]};
        assign diff  = trial - {1'b0, pden};

        always_ff @(posedge aclk) begin
            if (en[i]) begin
                den_reg[i] <= pden;
                if (!diff[64]) begin
                    rem_reg[i] <= diff[63:0];
                    quo_reg[i] <= {pquo[62:0], 1'b1};
                end else begin
                    rem_reg[i] <= trial[63:0];
                    quo_reg[i] <= {pquo[62:0], 1'b0};
                end
            end
        end
    end

    assign quo = quo_reg[esc_pkg::DIV_STAGES-1];

endmodule

/* sv/env_sensor_compensation.sv */
// Environmental sensor compensation top level: APB calibration registers and the
// compensation pipeline. Depends on esc_pkg, esc_mul64, esc_sdiv and the assert header.
//
// One raw burst in on s_*, one compensated result out on m_*. The pipeline takes
// one request per cycle unless a held output stalls it, and delivers results
// in order through 20 stages of multiply and add work and 64 stages of the
// radix-2 pressure divider, one quotient bit each. Every stage holds a valid bit
// and moves when the stage after it is empty or moving, so a held output stalls
// only as far back as the bubbles allow. Calibration words are read directly from
// the registers and must only be written while no request is in flight.
`include "env_sensor_compensation_assert.svh"

module env_sensor_compensation (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // Raw burst
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // raw_temp[19:0], raw_press[39:20], raw_hum[55:40]
    // Compensated result
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // temperature[15:0], pressure[47:16], humidity[64:48]
    output logic [2:0]  m_tuser    // temp_ok[0], press_ok[1], hum_ok[2]
);

    // Stage numbers
    localparam int S_IN  = 0;
    localparam int S_M1  = 1;
    localparam int S_M2  = 2;
    localparam int S_TF  = 3;
    localparam int S_V   = 4;
    localparam int S_MA  = 5;
    localparam int S_MB  = 6;
    localparam int S_MC  = 8;
    localparam int S_SUM = 9;
    localparam int S_NUM = 10;
    localparam int S_MD  = 12;
    localparam int S_DV  = 13;
    localparam int S_Q0  = 14;
    localparam int S_QL  = S_Q0 + esc_pkg::DIV_STAGES - 1;
    localparam int S_P   = S_QL + 1;
    localparam int S_ME  = S_P + 2;
    localparam int S_MF  = S_P + 4;
    localparam int S_OUT = S_MF + 1;
    localparam int NS    = S_OUT + 1;

    typedef struct packed {
        logic t_ok;
        logic p_ok;
        logic h_ok;
        logic neg;
    } flag_t;

    // ---------------- configuration registers ----------------
    logic [47:0] cal_temp_reg;
    logic [63:0] cal_press_low_reg;
    logic [63:0] cal_press_high_reg;
    logic [15:0] cal_press_last_reg;
    logic [63:0] cal_hum_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_temp_reg       <= '0;
            cal_press_low_reg  <= '0;
            cal_press_high_reg <= '0;
            cal_press_last_reg <= '0;
            cal_hum_reg        <= '0;
        end else if (wr_en) begin
            case (paddr[5:3])
                esc_pkg::REG_CAL_TEMP:       cal_temp_reg       <= pwdata[47:0];
                esc_pkg::REG_CAL_PRESS_LOW:  cal_press_low_reg  <= pwdata;
                esc_pkg::REG_CAL_PRESS_HIGH: cal_press_high_reg <= pwdata;
                esc_pkg::REG_CAL_PRESS_LAST: cal_press_last_reg <= pwdata[15:0];
                esc_pkg::REG_CAL_HUM:        cal_hum_reg        <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (paddr[5:3])
            esc_pkg::REG_CAL_TEMP:       prdata = {16'd0, cal_temp_reg};
            esc_pkg::REG_CAL_PRESS_LOW:  prdata = cal_press_low_reg;
            esc_pkg::REG_CAL_PRESS_HIGH: prdata = cal_press_high_reg;
            esc_pkg::REG_CAL_PRESS_LAST: prdata = {48'd0, cal_press_last_reg};
            esc_pkg::REG_CAL_HUM:        prdata = cal_hum_reg;
            default:                     prdata = 64'd0;
        endcase
    end

    // Calibration fields
    logic [31:0] t1, t2s, t3s;
    logic [63:0] p1, p2s, p3s, p4s, p5s, p6s, p7s, p8s, p9s;
    logic [31:0] h1, h2s, h3, h4s, h5s, h6s;

    assign t1  = {16'd0, cal_temp_reg[15:0]};
    assign t2s = esc_pkg::sx16_32(cal_temp_reg[31:16]);
    assign t3s = esc_pkg::sx16_32(cal_temp_reg[47:32]);
    assign p1  = {48'd0, cal_press_low_reg[15:0]};
    assign p2s = esc_pkg::sx16_64(cal_press_low_reg[31:16]);
    assign p3s = esc_pkg::sx16_64(cal_press_low_reg[47:32]);
    assign p4s = esc_pkg::sx16_64(cal_press_low_reg[63:48]);
    assign p5s = esc_pkg::sx16_64(cal_press_high_reg[15:0]);
    assign p6s = esc_pkg::sx16_64(cal_press_high_reg[31:16]);
    assign p7s = esc_pkg::sx16_64(cal_press_high_reg[47:32]);
    assign p8s = esc_pkg::sx16_64(cal_press_high_reg[63:48]);
    assign p9s = esc_pkg::sx16_64(cal_press_last_reg);
    assign h1  = {24'd0, cal_hum_reg[7:0]};
    assign h2s = esc_pkg::sx16_32(cal_hum_reg[23:8]);
    assign h3  = {24'd0, cal_hum_reg[31:24]};
    assign h4s = {{20{cal_hum_reg[43]}}, cal_hum_reg[43:32]};
    assign h5s = {{20{cal_hum_reg[55]}}, cal_hum_reg[55:44]};
    assign h6s = {{24{cal_hum_reg[63]}}, cal_hum_reg[63:56]};

    // ---------------- pipeline control ----------------
    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    // A stage loads when it is empty or its content moves on
    always_comb begin
        en[NS-1] = !v_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NS-1];

    // ---------------- input stage ----------------
    logic [19:0] in_rt, in_rp;
    logic [15:0] in_rh;
    logic        in_tok;
    logic [31:0] tx_reg, td_reg;
    logic [19:0] rp_line_reg [S_NUM];
    logic [15:0] rh_line_reg [S_V+1];
    flag_t       fl_line_reg [NS];

    assign in_rt  = s_tdata[19:0];
    assign in_rp  = s_tdata[39:20];
    assign in_rh  = s_tdata[55:40];
    assign in_tok = in_rt != esc_pkg::DIS_TP;

    always_ff @(posedge aclk) begin
        if (en[S_IN]) begin
            tx_reg         <= 32'(in_rt[19:3]) - {t1[30:0], 1'b0};
            td_reg         <= 32'(in_rt[19:4]) - t1;
        end
    end

    // Delay lines for raw fields
    always_ff @(posedge aclk) begin
        if (en[S_IN]) begin
            rp_line_reg[0] <= in_rp;
            rh_line_reg[0] <= in_rh;
        end
        for (int k = 1; k < S_NUM; k++) begin
            if (en[k]) rp_line_reg[k] <= rp_line_reg[k-1];
        end
        for (int k = 1; k <= S_V; k++) begin
            if (en[k]) rh_line_reg[k] <= rh_line_reg[k-1];
        end
    end

    // ---------------- temperature ----------------
    logic [31:0] ma_reg, mdd_reg, ta_reg, mb_reg, tf_reg;
    logic [31:0] t_scaled;
    logic [15:0] t_sat;

    always_ff @(posedge aclk) begin
        if (en[S_M1]) begin
            ma_reg  <= tx_reg * t2s;
            mdd_reg <= td_reg * td_reg;
        end
        if (en[S_M2]) begin
            ta_reg <= esc_pkg::asr32(ma_reg, 11);
            mb_reg <= esc_pkg::asr32(mdd_reg, 12) * t3s;
        end
        if (en[S_TF]) begin
            tf_reg <= ta_reg + esc_pkg::asr32(mb_reg, 14);
        end
    end

    // Hundredths of a degree, saturated to 16 bits
    always_comb begin
        t_scaled = esc_pkg::asr32({tf_reg[29:0], 2'b00} + tf_reg + esc_pkg::TEMP_RND, 8);
        if ($signed(t_scaled) > 32'sd32767) begin
            t_sat = 16'h7FFF;
        end else if ($signed(t_scaled) < -32'sd32768) begin
            t_sat = 16'h8000;
        end else begin
            t_sat = t_scaled[15:0];
        end
    end

    logic [15:0] tp_line_reg [NS-S_V];
    logic [63:0] v1_reg;
    logic [31:0] hv_reg;

    always_ff @(posedge aclk) begin
        if (en[S_V]) begin
            tp_line_reg[0] <= fl_line_reg[S_V-1].t_ok ? t_sat : 16'd0;
            v1_reg         <= {{32{tf_reg[31]}}, tf_reg} - esc_pkg::TF_PRESS_OFS;
            hv_reg         <= tf_reg - esc_pkg::TF_HUM_OFS;
        end
        for (int k = 1; k < NS - S_V; k++) begin
            if (en[S_V+k]) tp_line_reg[k] <= tp_line_reg[k-1];
        end
    end

    // ---------------- humidity ----------------
    logic [31:0] h5v_reg, vh6_reg, vh3_reg, xb_reg;
    logic [31:0] hx_reg, hy_reg, hz_reg, yz_reg, hx7_reg, wh_reg, hx8_reg;
    logic [31:0] hr_reg, qq_reg, hr10_reg, qh_reg, hr11_reg, rr_reg;
    logic [31:0] hq, hw, rr_clamp;
    logic [16:0] hm_line_reg [NS-S_DV];

    assign hq = esc_pkg::asr32(hr_reg, 15);
    assign hw = esc_pkg::asr32(wh_reg + esc_pkg::HUM_W_RND, 14);

    always_ff @(posedge aclk) begin
        if (en[S_V+1]) begin
            h5v_reg <= h5s * hv_reg;
            vh6_reg <= hv_reg * h6s;
            vh3_reg <= hv_reg * h3;
            xb_reg  <= {2'b00, rh_line_reg[S_V], 14'd0} - {h4s[11:0], 20'd0}
                       + esc_pkg::HUM_RND;
        end
        if (en[S_V+2]) begin
            hx_reg <= esc_pkg::asr32(xb_reg - h5v_reg, 15);
            hy_reg <= esc_pkg::asr32(vh6_reg, 10);
            hz_reg <= esc_pkg::asr32(vh3_reg, 11) + esc_pkg::HUM_Z_OFS;
        end
        if (en[S_V+3]) begin
            yz_reg  <= hy_reg * hz_reg;
            hx7_reg <= hx_reg;
        end
        if (en[S_V+4]) begin
            wh_reg  <= (esc_pkg::asr32(yz_reg, 10) + esc_pkg::HUM_W_OFS) * h2s;
            hx8_reg <= hx7_reg;
        end
        if (en[S_V+5]) begin
            hr_reg <= hx8_reg * hw;
        end
        if (en[S_V+6]) begin
            qq_reg   <= hq * hq;
            hr10_reg <= hr_reg;
        end
        if (en[S_V+7]) begin
            qh_reg   <= esc_pkg::asr32(qq_reg, 7) * h1;
            hr11_reg <= hr10_reg;
        end
        if (en[S_V+8]) begin
            rr_reg <= hr11_reg - esc_pkg::asr32(qh_reg, 4);
        end
    end

    // Clamp to 0..100 percent
    always_comb begin
        if (rr_reg[31]) begin
            rr_clamp = 32'd0;
        end else if (rr_reg > esc_pkg::HUM_MAX) begin
            rr_clamp = esc_pkg::HUM_MAX;
        end else begin
            rr_clamp = rr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[S_DV]) begin
            hm_line_reg[0] <= fl_line_reg[S_DV-1].h_ok ? rr_clamp[28:12] : 17'd0;
        end
        for (int k = 1; k < NS - S_DV; k++) begin
            if (en[S_DV+k]) hm_line_reg[k] <= hm_line_reg[k-1];
        end
    end

    // ---------------- pressure ----------------
    logic [63:0] m1_p, m2_p, m3_p, m4_p, m5_p, m6_p, m7_p;
    logic [63:0] c7_p5_reg, c7_p2_reg, c8_p5_reg, c8_p2_reg;
    logic [63:0] v2_reg, v1b_reg, n0_reg, n1_reg;
    logic [63:0] v1c, un_reg, ud_reg;

    esc_mul64 u_mul_sq (.aclk(aclk), .en_a(en[S_MA]), .en_b(en[S_MB]),
                        .a(v1_reg), .b(v1_reg), .p(m1_p));
    esc_mul64 u_mul_p5 (.aclk(aclk), .en_a(en[S_MA]), .en_b(en[S_MB]),
                        .a(v1_reg), .b(p5s), .p(m2_p));
    esc_mul64 u_mul_p2 (.aclk(aclk), .en_a(en[S_MA]), .en_b(en[S_MB]),
                        .a(v1_reg), .b(p2s), .p(m3_p));
    esc_mul64 u_mul_p6 (.aclk(aclk), .en_a(en[S_MB+1]), .en_b(en[S_MC]),
                        .a(m1_p), .b(p6s), .p(m4_p));
    esc_mul64 u_mul_p3 (.aclk(aclk), .en_a(en[S_MB+1]), .en_b(en[S_MC]),
                        .a(m1_p), .b(p3s), .p(m5_p));

    always_ff @(posedge aclk) begin
        if (en[S_MB+1]) begin
            c7_p5_reg <= m2_p;
            c7_p2_reg <= m3_p;
        end
        if (en[S_MC]) begin
            c8_p5_reg <= c7_p5_reg;
            c8_p2_reg <= c7_p2_reg;
        end
        if (en[S_SUM]) begin
            v2_reg  <= m4_p + {c8_p5_reg[46:0], 17'd0} + {p4s[28:0], 35'd0};
            v1b_reg <= esc_pkg::asr64(m5_p, 8) + {c8_p2_reg[51:0], 12'd0};
        end
        if (en[S_NUM]) begin
            n0_reg <= esc_pkg::P1_BIAS + v1b_reg;
            n1_reg <= {esc_pkg::PRESS_BASE[32:0] - 33'(rp_line_reg[S_NUM-1]), 31'd0}
                      - v2_reg;
        end
    end

    esc_mul64 u_mul_p1 (.aclk(aclk), .en_a(en[S_NUM+1]), .en_b(en[S_MD]),
                        .a(n0_reg), .b(p1), .p(m6_p));
    esc_mul64 u_mul_sc (.aclk(aclk), .en_a(en[S_NUM+1]), .en_b(en[S_MD]),
                        .a(n1_reg), .b(esc_pkg::PRESS_SCALE), .p(m7_p));

    assign v1c = esc_pkg::asr64(m6_p, 33);

    // Divider operands as magnitudes; a zero divisor drops the pressure flag
    always_ff @(posedge aclk) begin
        if (en[S_DV]) begin
            un_reg <= m7_p[63] ? 64'd0 - m7_p : m7_p;
            ud_reg <= v1c[63] ? 64'd0 - v1c : v1c;
        end
    end

    // Flag line, with the divisor check folded in ahead of the divider
    always_ff @(posedge aclk) begin
        if (en[S_IN]) begin
            fl_line_reg[0] <= '{t_ok: in_tok,
                                p_ok: in_tok && (in_rp != esc_pkg::DIS_TP),
                                h_ok: in_tok && (in_rh != esc_pkg::DIS_HUM),
                                neg:  1'b0};
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                if (k == S_DV) begin
                    fl_line_reg[k] <= '{t_ok: fl_line_reg[k-1].t_ok,
                                        p_ok: fl_line_reg[k-1].p_ok && (v1c != 64'd0),
                                        h_ok: fl_line_reg[k-1].h_ok,
                                        neg:  m7_p[63] ^ v1c[63]};
                end else begin
                    fl_line_reg[k] <= fl_line_reg[k-1];
                end
            end
        end
    end

    logic [63:0] q_div;

    esc_sdiv u_div (
        .aclk (aclk),
        .en   (en[S_QL:S_Q0]),
        .num  (un_reg),
        .den  (ud_reg),
        .quo  (q_div)
    );

    logic [63:0] pq_reg, pc1_reg, pc2_reg, pc3_reg, pc4_reg, e2a_reg, e2b_reg;
    logic [63:0] m8_p, m9_p, m10_p;
    logic [63:0] p_fin;

    always_ff @(posedge aclk) begin
        if (en[S_P]) begin
            pq_reg <= fl_line_reg[S_P-1].neg ? 64'd0 - q_div : q_div;
        end
    end

    esc_mul64 u_mul_ss (.aclk(aclk), .en_a(en[S_P+1]), .en_b(en[S_ME]),
                        .a(esc_pkg::asr64(pq_reg, 13)), .b(esc_pkg::asr64(pq_reg, 13)),
                        .p(m8_p));
    esc_mul64 u_mul_p8 (.aclk(aclk), .en_a(en[S_P+1]), .en_b(en[S_ME]),
                        .a(p8s), .b(pq_reg), .p(m9_p));
    esc_mul64 u_mul_p9 (.aclk(aclk), .en_a(en[S_ME+1]), .en_b(en[S_MF]),
                        .a(p9s), .b(m8_p), .p(m10_p));

    always_ff @(posedge aclk) begin
        if (en[S_P+1])  pc1_reg <= pq_reg;
        if (en[S_ME])   pc2_reg <= pc1_reg;
        if (en[S_ME+1]) begin
            pc3_reg <= pc2_reg;
            e2a_reg <= esc_pkg::asr64(m9_p, 19);
        end
        if (en[S_MF]) begin
            pc4_reg <= pc3_reg;
            e2b_reg <= e2a_reg;
        end
    end

    assign p_fin = esc_pkg::asr64(pc4_reg + esc_pkg::asr64(m10_p, 25) + e2b_reg, 8)
                   + {p7s[59:0], 4'd0};

    // ---------------- output stage ----------------
    logic [31:0] pr_out_reg;

    always_ff @(posedge aclk) begin
        if (en[S_OUT]) begin
            pr_out_reg <= fl_line_reg[S_OUT-1].p_ok ? p_fin[31:0] : 32'd0;
        end
    end

    assign m_tdata = {7'd0, hm_line_reg[NS-S_DV-1], pr_out_reg, tp_line_reg[NS-S_V-1]};
    assign m_tuser = {fl_line_reg[NS-1].h_ok, fl_line_reg[NS-1].p_ok,
                      fl_line_reg[NS-1].t_ok};

    // ---------------- checks ----------------
    `ESC_ASSERT_IMP(a_press_zero, aclk, aresetn, m_tvalid && !m_tuser[1],
        m_tdata[47:16] == 32'd0, "pressure not zero with press_ok low")
    `ESC_ASSERT_IMP(a_hum_zero, aclk, aresetn, m_tvalid && !m_tuser[2],
        m_tdata[64:48] == 17'd0, "humidity not zero with hum_ok low")
    `ESC_ASSERT_IMP(a_stall_src, aclk, aresetn, !s_tready,
        m_tvalid && !m_tready, "input stalled without output backpressure")
    `ESC_ASSERT_NXT(a_enter, aclk, aresetn, s_tvalid && s_tready,
        v_reg[0], "accepted request missing from first stage")

endmodule

/* test/env_sensor_compensation_checker.sv */
// Result checker for env_sensor_compensation: watches the calibration port and both
// streams, predicts each compensated result and compares it. Depends on esc_pkg.
module env_sensor_compensation_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,   // raw_temp[19:0], raw_press[39:20], raw_hum[55:40]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,   // temperature[15:0], pressure[47:16], humidity[64:48]
    input  logic [2:0]  m_tuser,   // temp_ok[0], press_ok[1], hum_ok[2]
    output int          fail_count,
    output int          pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  flags;
        logic [71:0] data;
    } comp_result_t;

    logic [47:0] cal_t;
    logic [63:0] cal_pl, cal_ph, cal_h;
    logic [15:0] cal_p9;
    comp_result_t expected_results[$];

    function automatic logic [63:0] sxt(input logic [63:0] v, input int pos, input int bits);
        logic [63:0] m;
        logic [63:0] r;
        m = (64'd1 << bits) - 64'd1;
        r = (v >> pos) & m;
        if (r[bits-1]) r = r | ~m;
        return r;
    endfunction

    function automatic logic [31:0] sra32(input logic [31:0] x, input int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] sra64(input logic [63:0] x, input int n);
        return $signed(x) >>> n;
    endfunction

    // Compensate one raw burst against the current calibration words
    function automatic comp_result_t compensate(input logic [55:0] raw);
        logic [19:0] rt, rp;
        logic [15:0] rh;
        logic t_ok, p_ok, h_ok;
        logic [31:0] t1, t2, t3, a, d, b, tf, tt;
        logic [15:0] t_out;
        logic [31:0] p_out;
        logic [16:0] h_out;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, s, e1, e2, un, ud, q, nm;
        logic [31:0] h1, h2, h3, h4, h5, h6, v, x, y, z, w, r, hq;
        comp_result_t res;
        rt = raw[19:0];
        rp = raw[39:20];
        rh = raw[55:40];
        t_ok = rt != esc_pkg::DIS_TP;
        p_ok = t_ok && rp != esc_pkg::DIS_TP;
        h_ok = t_ok && rh != esc_pkg::DIS_HUM;
        t_out = '0;
        p_out = '0;
        h_out = '0;
        // temperature
        t1 = {16'd0, cal_t[15:0]};
        t2 = 32'(sxt({16'd0, cal_t}, 16, 16));
        t3 = 32'(sxt({16'd0, cal_t}, 32, 16));
        a = sra32((({12'd0, rt} >> 3) - (t1 << 1)) * t2, 11);
        d = ({12'd0, rt} >> 4) - t1;
        b = sra32(sra32(d * d, 12) * t3, 14);
        tf = a + b;
        tt = sra32(tf * 32'd5 + 32'd128, 8);
        if ($signed(tt) > 32'sd32767) tt = 32'sd32767;
        if ($signed(tt) < -32'sd32768) tt = -32'sd32768;
        if (t_ok) t_out = tt[15:0];
        // pressure
        if (p_ok) begin
            p1 = {48'd0, cal_pl[15:0]};
            p2 = sxt(cal_pl, 16, 16);
            p3 = sxt(cal_pl, 32, 16);
            p4 = sxt(cal_pl, 48, 16);
            p5 = sxt(cal_ph, 0, 16);
            p6 = sxt(cal_ph, 16, 16);
            p7 = sxt(cal_ph, 32, 16);
            p8 = sxt(cal_ph, 48, 16);
            p9 = sxt({48'd0, cal_p9}, 0, 16);
            v1 = {{32{tf[31]}}, tf} - 64'd128000;
            v2 = v1 * v1 * p6;
            v2 = v2 + ((v1 * p5) << 17);
            v2 = v2 + (p4 << 35);
            v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
            v1 = sra64(((64'd1 << 47) + v1) * p1, 33);
            if (v1 == 64'd0) begin
                p_ok = 1'b0;
            end else begin
                p = 64'd1048576 - {44'd0, rp};
                nm = ((p << 31) - v2) * 64'd3125;
                un = nm[63] ? -nm : nm;
                ud = v1[63] ? -v1 : v1;
                q = un / ud;
                p = (nm[63] != v1[63]) ? -q : q;
                s = sra64(p, 13);
                e1 = sra64(p9 * s * s, 25);
                e2 = sra64(p8 * p, 19);
                p = sra64(p + e1 + e2, 8) + (p7 << 4);
                p_out = p[31:0];
            end
        end
        // humidity
        if (h_ok) begin
            h1 = {24'd0, cal_h[7:0]};
            h2 = 32'(sxt(cal_h, 8, 16));
            h3 = {24'd0, cal_h[31:24]};
            h4 = 32'(sxt(cal_h, 32, 12));
            h5 = 32'(sxt(cal_h, 44, 12));
            h6 = 32'(sxt(cal_h, 56, 8));
            v = tf - 32'd76800;
            x = sra32(({16'd0, rh} << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
            y = sra32(v * h6, 10);
            z = sra32(v * h3, 11) + 32'd32768;
            w = sra32(y * z, 10) + 32'd2097152;
            w = sra32(w * h2 + 32'd8192, 14);
            r = x * w;
            hq = sra32(r, 15);
            hq = sra32(hq * hq, 7);
            r = r - sra32(hq * h1, 4);
            if ($signed(r) < 0) r = 32'd0;
            if ($signed(r) > 32'sd419430400) r = 32'd419430400;
            h_out = r[28:12];
        end
        res.data = {7'd0, h_out, p_out, t_out};
        res.flags = {h_ok, p_ok, t_ok};
        return res;
    endfunction

    always @(posedge aclk) begin
        comp_result_t exp_r;
        if (!aresetn) begin
            cal_t <= '0;
            cal_pl <= '0;
            cal_ph <= '0;
            cal_p9 <= '0;
            cal_h <= '0;
            fail_count <= 0;
            pending_count <= 0;
            expected_results.delete();
        end else begin
            // calibration writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[5:3])
                    esc_pkg::REG_CAL_TEMP:       cal_t <= pwdata[47:0];
                    esc_pkg::REG_CAL_PRESS_LOW:  cal_pl <= pwdata;
                    esc_pkg::REG_CAL_PRESS_HIGH: cal_ph <= pwdata;
                    esc_pkg::REG_CAL_PRESS_LAST: cal_p9 <= pwdata[15:0];
                    esc_pkg::REG_CAL_HUM:        cal_h <= pwdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) expected_results.push_back(compensate(s_tdata));
            // compare results against the oldest prediction
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10) $display("unexpected result %h %b", m_tdata, m_tuser);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.data[15:0] !== m_tdata[15:0] ||
                        exp_r.data[47:16] !== m_tdata[47:16] ||
                        exp_r.data[64:48] !== m_tdata[64:48] ||
                        exp_r.flags !== m_tuser) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display({"mismatch: expected t=%h p=%h h=%h ok=%b, ",
                                      "got t=%h p=%h h=%h ok=%b"},
                                exp_r.data[15:0], exp_r.data[47:16], exp_r.data[64:48],
                                exp_r.flags, m_tdata[15:0], m_tdata[47:16], m_tdata[64:48],
                                m_tuser);
                    end
                end
            end
            pending_count <= expected_results.size();
        end
    end
endmodule

/* test/tb_env_sensor_compensation.sv */
// Testbench top for env_sensor_compensation: calibration writes, directed and
// random bursts with random idling. Depends on esc_pkg, the design and the checker.
module tb_env_sensor_compensation;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;   // raw_temp[19:0], raw_press[39:20], raw_hum[55:40]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;        // temperature[15:0], pressure[47:16], humidity[64:48]
    logic [2:0]  m_tuser;        // temp_ok[0], press_ok[1], hum_ok[2]
    int          fail_count, pending_count;
    int          send_idle_pct = 9, recv_idle_pct = 83;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    env_sensor_compensation uut (.*);

    env_sensor_compensation_checker chk (.*);

    // receiver stalls at random
    always @(negedge aclk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // setup and access cycle, then the bus goes idle before the task returns
    task automatic write_cal(input logic [2:0] idx, input logic [63:0] val);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 3'b000}; pwdata <= val;
        @(negedge aclk) penable <= 1'b1;
        @(negedge aclk) begin
            psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        end
        @(negedge aclk);
    endtask

    // valid stays high past the accept; the next call or the caller drops it
    task automatic send_burst(input logic [19:0] rt, input logic [19:0] rp,
                              input logic [15:0] rh);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {rh, rp, rt};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // drain, let the pipeline settle, then load a calibration set
    task automatic load_cal(input int mode);
        logic [63:0] v [5];
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        case (mode)
            0: begin
                // typical factory values
                v[0] = {16'd0, 16'd50, 16'd26435, 16'd27504};
                v[1] = {16'd2855, 16'd3024, -16'sd10685, 16'd36477};
                v[2] = {16'sd15500, -16'sd12000, 16'sd9900, -16'sd7};
                v[3] = 64'd6000;
                v[4] = {8'sd30, 12'sd0, 12'sd333, 8'd0, 16'sd367, 8'd75};
            end
            1: for (int i = 0; i < 5; i++) v[i] = '1;
            2: begin
                for (int i = 0; i < 5; i++) v[i] = 64'h8000_8000_8000_8000;
                v[4] = 64'h8080_0800_8080_0080;
            end
            3: for (int i = 0; i < 5; i++) v[i] = '0;
            default: for (int i = 0; i < 5; i++) v[i] = rand64();
        endcase
        write_cal(esc_pkg::REG_CAL_TEMP, v[0]);
        write_cal(esc_pkg::REG_CAL_PRESS_LOW, v[1]);
        write_cal(esc_pkg::REG_CAL_PRESS_HIGH, v[2]);
        write_cal(esc_pkg::REG_CAL_PRESS_LAST, v[3]);
        write_cal(esc_pkg::REG_CAL_HUM, v[4]);
    endtask

    task automatic send_random(input int n);
        logic [19:0] rt, rp;
        logic [15:0] rh;
        for (int i = 0; i < n; i++) begin
            rt = 20'($urandom()); rp = 20'($urandom()); rh = 16'($urandom());
            case ($urandom_range(9))
                0: rt = esc_pkg::DIS_TP;
                1: rp = esc_pkg::DIS_TP;
                2: rh = esc_pkg::DIS_HUM;
                3: begin
                    rt = 20'($urandom_range(400000, 600000));
                    rp = 20'($urandom_range(250000, 450000));
                    rh = 16'($urandom_range(20000, 40000));
                end
                default: ;
            endcase
            send_burst(rt, rp, rh);
        end
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // directed bursts under typical calibration
        load_cal(0);
        send_burst(20'd519888, 20'd415148, 16'd30000);
        send_burst('0, '0, '0);
        send_burst('1, '1, '1);
        send_burst(esc_pkg::DIS_TP, 20'd400000, 16'd30000);
        send_burst(20'd519888, esc_pkg::DIS_TP, 16'd30000);
        send_burst(20'd519888, 20'd415148, esc_pkg::DIS_HUM);
        send_burst(esc_pkg::DIS_TP, esc_pkg::DIS_TP, esc_pkg::DIS_HUM);
        send_burst(20'h7FFFF, 20'h80001, 16'h7FFF);
        send_burst(20'h80001, 20'h7FFFF, 16'h8001);
        // zero calibration gives a zero divisor
        load_cal(3);
        send_burst(20'd519888, 20'd415148, 16'd30000);
        send_burst('1, '0, '1);
        load_cal(1);
        send_burst('0, '1, '0);
        send_burst(20'd519888, 20'd415148, 16'd30000);
        load_cal(2);
        send_burst('1, '1, '1);
        send_burst(20'd300000, 20'd300000, 16'd20000);
        // random phases with changing calibration and idling
        for (int ph = 0; ph < 9; ph++) begin
            if (ph == 3) begin send_idle_pct = 83; recv_idle_pct = 9; end
            if (ph == 6) begin send_idle_pct = 0; recv_idle_pct = 0; end
            load_cal(ph % 3 == 0 ? 0 : 4);
            send_random(205);
        end
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (fail_count == 0) $display("tb_env_sensor_compensation passed");
        else $display("tb_env_sensor_compensation failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("tb_env_sensor_compensation failed");
        $finish;
    end
endmodule

/* sim.f */
+incdir+sv
sv/esc_pkg.sv
sv/esc_mul64.sv
sv/esc_sdiv.sv
sv/env_sensor_compensation.sv
test/env_sensor_compensation_checker.sv
test/tb_env_sensor_compensation.sv
